@@ rtl/smo_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants of the sliding mode rotor angle observer
// no dependencies

package smo_pkg;

  typedef struct packed {
    logic signed [31:0] volt_alpha;
    logic signed [31:0] volt_beta;
    logic signed [31:0] curr_alpha;
    logic signed [31:0] curr_beta;
  } smo_in_t;

  typedef struct packed {
    logic signed [18:0] rotor_angle;
    logic signed [31:0] emf_alpha_out;
    logic signed [31:0] emf_beta_out;
  } smo_out_t;

  // configuration register indexes
  localparam logic [2:0] REG_DECAY    = 3'd0;
  localparam logic [2:0] REG_INPUT    = 3'd1;
  localparam logic [2:0] REG_SLIDE    = 3'd2;
  localparam logic [2:0] REG_FILTER   = 3'd3;
  localparam logic [2:0] REG_BAND     = 3'd4;
  localparam logic [2:0] REG_BAND_INV = 3'd5;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_U1,      // acc = sat(v - emf)
    OP_U2,      // u = sat(acc - slide)
    OP_MUL_F,   // prod = F * est
    OP_MUL_G,   // t = prod, prod = G * u
    OP_EST,     // est = sat(t + prod)
    OP_ERR,     // e = sat(est - i)
    OP_MUL_K,   // prod = K * e
    OP_MUL_INV, // prod = prod * inv
    OP_SLIDE,   // slide = control
    OP_DIFF,    // d = sat(slide - emf)
    OP_MUL_KF,  // prod = Kf * d
    OP_EMF,     // emf = sat(emf + prod)
    OP_CORDIC_INIT
  } smo_op_t;

  typedef struct packed {
    smo_op_t    op;
    logic       axis;   // 0 alpha, 1 beta
    logic       load;   // latch input item
    logic       cstep;  // one cordic iteration
  } smo_cmd_t;

  localparam int AtanLen = 24;
  localparam logic [31:0] PiQ30 = 32'd3373259426;

  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    unique case (i)
      5'd0: atan_q30 = 30'd843314857;
      5'd1: atan_q30 = 30'd497837830;
      5'd2: atan_q30 = 30'd263043837;
      5'd3: atan_q30 = 30'd133525159;
      5'd4: atan_q30 = 30'd67021687;
      5'd5: atan_q30 = 30'd33543516;
      5'd6: atan_q30 = 30'd16775851;
      5'd7: atan_q30 = 30'd8388437;
      5'd8: atan_q30 = 30'd4194283;
      5'd9: atan_q30 = 30'd2097149;
      default: atan_q30 = 30'd1 << (30 - 10 - (i - 5'd10) + 0);
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) sat32 = 32'h7fffffff;
    else if (v < -66'sd2147483648) sat32 = 32'h80000000;
    else sat32 = v[31:0];
  endfunction

endpackage

@@ rtl/smo_ctrl.sv @@
`timescale 1ns / 1ps
// sequencer of the observer: walks both axes, then the cordic iterations
// depends on smo_pkg

module smo_ctrl import smo_pkg::*; #(
  parameter int CORDIC_STEPS = 18
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output smo_cmd_t cmd
);

  localparam int NSteps = (CORDIC_STEPS < AtanLen) ? CORDIC_STEPS : AtanLen;

  typedef enum logic [1:0] {S_IDLE, S_AXIS, S_CORDIC, S_OUT} state_t;

  state_t     state;
  smo_op_t    op;
  logic       axis;
  logic [4:0] cnt;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd       = '0;
    cmd.op    = OP_NONE;
    cmd.axis  = axis;
    cmd.load  = (state == S_IDLE) && in_valid;
    if (state == S_AXIS) cmd.op = op;
    cmd.cstep = (state == S_CORDIC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_U1;
      axis  <= 1'b0;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_AXIS;
            op    <= OP_U1;
            axis  <= 1'b0;
          end
        end
        S_AXIS: begin
          if (op == OP_EMF) begin
            if (axis) begin
              op <= OP_CORDIC_INIT;
            end else begin
              axis <= 1'b1;
              op   <= OP_U1;
            end
          end else if (op == OP_CORDIC_INIT) begin
            state <= S_CORDIC;
            cnt   <= '0;
          end else begin
            op <= smo_op_t'(op + 4'd1);
          end
        end
        S_CORDIC: begin
          if (cnt == 5'(NSteps - 1)) state <= S_OUT;
          cnt <= cnt + 5'd1;
        end
        S_OUT: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/smo_dp.sv @@
`timescale 1ns / 1ps
// observer datapath: one shared multiplier, saturating adder, cordic unit
// depends on smo_pkg

module smo_dp import smo_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  smo_cmd_t    cmd,
  input  smo_in_t     in_item,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data,
  output smo_out_t    out_item
);

  localparam int S = 30 - FRAC_BITS;

  logic [16:0] decay_gain, filter_gain;
  logic [30:0] input_gain, slide_gain, band, band_inv;

  logic signed [31:0] est [2];
  logic signed [31:0] slide [2];
  logic signed [31:0] emf [2];

  smo_in_t            item;
  logic signed [31:0] acc, t, err;
  logic signed [31:0] prod;
  logic signed [31:0] ma, mb;
  logic signed [63:0] mfull;
  logic signed [31:0] mres;

  // cordic state
  logic signed [43:0] cx, cy;
  logic signed [33:0] cz;
  logic [4:0]         ci;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_gain  <= '0;
      input_gain  <= '0;
      slide_gain  <= '0;
      filter_gain <= '0;
      band        <= '0;
      band_inv    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DECAY:    decay_gain  <= cfg_data[16:0];
        REG_INPUT:    input_gain  <= cfg_data;
        REG_SLIDE:    slide_gain  <= cfg_data;
        REG_FILTER:   filter_gain <= cfg_data[16:0];
        REG_BAND:     band        <= cfg_data;
        REG_BAND_INV: band_inv    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [31:0] v_ax, i_ax, ctl, abs_e;
  assign v_ax = cmd.axis ? item.volt_beta : item.volt_alpha;
  assign i_ax = cmd.axis ? item.curr_beta : item.curr_alpha;

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_MUL_F:   begin ma = $signed({15'd0, decay_gain});  mb = est[cmd.axis]; end
      OP_MUL_G:   begin ma = $signed({1'b0, input_gain});   mb = acc; end
      OP_MUL_K:   begin ma = $signed({1'b0, slide_gain});   mb = err; end
      OP_MUL_INV: begin ma = prod;                          mb = $signed({1'b0, band_inv}); end
      OP_MUL_KF:  begin ma = $signed({15'd0, filter_gain}); mb = acc; end
      default: ;
    endcase
    mfull = ma * mb;
    mres  = sat32(66'(mfull >>> FRAC_BITS));
    abs_e = err[31] ? -err : err;
    if ((err[31] ? (33'sd0 - 33'(err)) : 33'(err)) < $signed({2'b0, band}))
      ctl = prod;
    else if (!err[31])
      ctl = $signed({1'b0, slide_gain});
    else
      ctl = -$signed({1'b0, slide_gain});
  end

  // cordic, normalisation and pre-rotation, then one iteration a cycle
  logic signed [43:0] nx, ny, px, py, sx, sy;
  logic signed [33:0] pz;
  logic signed [31:0] yin, xin;
  logic [31:0]        ax, ay, amax;
  logic [29:0]        at;
  int                 lz;
  int                 msb;

  always_comb begin
    yin = sat32(66'sd0 - 66'(emf[0]));
    xin = emf[1];
    // scale so the larger magnitude lands in [2^40, 2^41)
    ax = xin[31] ? $unsigned(-xin) : $unsigned(xin);
    ay = yin[31] ? $unsigned(-yin) : $unsigned(yin);
    amax = (ax > ay) ? ax : ay;
    msb = 0;
    for (int b = 0; b < 32; b++) begin
      if (amax[b]) msb = b;
    end
    lz = 40 - msb;
    sx = 44'(xin) <<< lz;
    sy = 44'(yin) <<< lz;
    px = sx;
    py = sy;
    pz = '0;
    if (xin < 0) begin
      if (yin >= 0) begin
        px = sy; py = -sx; pz = 34'($signed({2'b0, PiQ30 >> 1}));
      end else begin
        px = -sy; py = sx; pz = -34'($signed({2'b0, PiQ30 >> 1}));
      end
    end
    at = atan_q30(ci);
    if (cy > 0) begin
      nx = cx + (cy >>> ci);
      ny = cy - (cx >>> ci);
    end else begin
      nx = cx - (cy >>> ci);
      ny = cy + (cx >>> ci);
    end
  end

  logic signed [33:0] zr, lim;
  assign lim = 34'((($signed({2'b0, PiQ30})) + (34'sd1 <<< (S - 1))) >>> S);
  assign zr  = (cz + (34'sd1 <<< (S - 1))) >>> S;

  always_ff @(posedge clk) begin
    if (cmd.load) item <= in_item;
    if (rst) begin
      est   <= '{default: '0};
      slide <= '{default: '0};
      emf   <= '{default: '0};
    end else begin
      case (cmd.op)
        OP_U1:      acc <= sat32(66'(v_ax) - 66'(emf[cmd.axis]));
        OP_U2:      acc <= sat32(66'(acc) - 66'(slide[cmd.axis]));
        OP_MUL_F:   prod <= mres;
        OP_MUL_G:   begin t <= prod; prod <= mres; end
        OP_EST:     est[cmd.axis] <= sat32(66'(t) + 66'(prod));
        OP_ERR:     err <= sat32(66'(est[cmd.axis]) - 66'(i_ax));
        OP_MUL_K:   prod <= mres;
        OP_MUL_INV: prod <= mres;
        OP_SLIDE:   slide[cmd.axis] <= ctl;
        OP_DIFF:    acc <= sat32(66'(slide[cmd.axis]) - 66'(emf[cmd.axis]));
        OP_MUL_KF:  prod <= mres;
        OP_EMF:     emf[cmd.axis] <= sat32(66'(emf[cmd.axis]) + 66'(prod));
        OP_CORDIC_INIT: begin cx <= px; cy <= py; cz <= pz; ci <= '0; end
        default: ;
      endcase
      if (cmd.cstep) begin
        cx <= nx; cy <= ny; ci <= ci + 5'd1;
        cz <= (cy > 0) ? cz + 34'(at) : cz - 34'(at);
      end
    end
  end

  always_comb begin
    out_item.emf_alpha_out = emf[0];
    out_item.emf_beta_out  = emf[1];
    if (emf[0] == 0 && emf[1] == 0) out_item.rotor_angle = '0;
    else if (zr > lim) out_item.rotor_angle = lim[18:0];
    else if (zr < -lim) out_item.rotor_angle = 19'(-lim);
    else out_item.rotor_angle = zr[18:0];
  end

  logic unused;
  assign unused = ^abs_e;

endmodule

@@ rtl/sliding_mode_rotor_angle_observer.sv @@
`timescale 1ns / 1ps
// sliding mode back-emf observer with cordic rotor angle readout
// sequence: after an input is accepted, each axis runs its observer steps in turn,
// then a cordic set-up step and CORDIC_STEPS iterations (capped at AtanLen)
// one item at a time: no new item is accepted until the result has been taken
// reset: synchronous active high, clears gains, observer state and controller to zero

module sliding_mode_rotor_angle_observer import smo_pkg::*; #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 18
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  smo_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output smo_out_t    out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  smo_cmd_t cmd;

  // controller sequences the shared datapath
  smo_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .cmd
  );

  // datapath holds state, gains and cordic
  smo_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst, .cmd, .in_item(in_data), .cfg_we, .cfg_index, .cfg_data,
    .out_item(out_data)
  );

`ifndef SYNTHESIS
  // a result holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("result lost");
  // never accept while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("overlap");
`endif

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// self-checking bench for the sliding mode rotor angle observer
// depends on smo_pkg and sliding_mode_rotor_angle_observer

module tb import smo_pkg::*; ();

  localparam int FracBits = 16;
  localparam int CordicSteps = 18;
  localparam int Latency = 80;
  localparam int CycleLimit = 400000;
  localparam logic [2:0] RegUnused = 3'd7;
  localparam logic [2:0] RegSpare = 3'd6;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  smo_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  smo_out_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;

  sliding_mode_rotor_angle_observer #(
    .FRAC_BITS(FracBits),
    .CORDIC_STEPS(CordicSteps)
  ) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // observer copy: gains and per-axis state
  longint gain_f, gain_g, gain_k, gain_kf, band, band_inv;
  longint est_a, est_b, ctl_a, ctl_b, emf_a, emf_b;

  smo_in_t  pending_items[$];
  smo_out_t expected_angles[$];
  int errors = 0;
  int accepted_in = 0;
  int checked_out = 0;
  int cycles = 0;
  bit long_hold = 1'b0;
  bit hold_pending = 1'b0;

  longint atan_tab[24] = '{843314857, 497837830, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // >>> on longint is arithmetic, i.e. floor
  function automatic longint qmul(longint a, longint b);
    return clamp32((a * b) >>> FracBits);
  endfunction

  function automatic longint sliding_control(longint err);
    longint mag;
    mag = err < 0 ? -err : err;
    if (mag < band) return qmul(qmul(gain_k, err), band_inv);
    if (err >= band) return gain_k;
    return -gain_k;
  endfunction

  function automatic longint cordic_angle(longint y, longint x);
    longint z, ax, ay, t, dx, dy, lim, res;
    int sh;
    z = 0;
    sh = 30 - FracBits;
    if (x == 0 && y == 0) return 0;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    while ((ax > ay ? ax : ay) < (64'sd1 <<< 40)) begin
      ax *= 2; ay *= 2; x *= 2; y *= 2;
    end
    // fold the left half plane onto the right
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 64'sd3373259426 / 2;
      end else begin
        x = -y; y = t; z = -(64'sd3373259426 / 2);
      end
    end
    for (int i = 0; i < CordicSteps && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += atan_tab[i];
      end else begin
        x -= dx; y += dy; z -= atan_tab[i];
      end
    end
    lim = (64'sd3373259426 + (64'sd1 <<< (sh - 1))) >>> sh;
    res = (z + (64'sd1 <<< (sh - 1))) >>> sh;
    if (res > lim) res = lim;
    if (res < -lim) res = -lim;
    return res;
  endfunction

  function automatic smo_out_t observe_step(smo_in_t it);
    longint ua, ub;
    smo_out_t r;
    ua = clamp32(clamp32(longint'(it.volt_alpha) - emf_a) - ctl_a);
    ub = clamp32(clamp32(longint'(it.volt_beta) - emf_b) - ctl_b);
    est_a = clamp32(qmul(gain_f, est_a) + qmul(gain_g, ua));
    est_b = clamp32(qmul(gain_f, est_b) + qmul(gain_g, ub));
    ctl_a = sliding_control(clamp32(est_a - longint'(it.curr_alpha)));
    ctl_b = sliding_control(clamp32(est_b - longint'(it.curr_beta)));
    emf_a = clamp32(emf_a + qmul(gain_kf, clamp32(ctl_a - emf_a)));
    emf_b = clamp32(emf_b + qmul(gain_kf, clamp32(ctl_b - emf_b)));
    r.rotor_angle = 19'(cordic_angle(clamp32(-emf_a), emf_b));
    r.emf_alpha_out = 32'(emf_a);
    r.emf_beta_out = 32'(emf_b);
    return r;
  endfunction

  // handshake sampled at the rising edge for the falling-edge driver
  logic in_stall_s = 1'b0;
  always @(posedge clk) in_stall_s <= in_stall;

  // driver: one item at a time from the pending queue, random gaps of 0..3
  int in_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall_s) begin
        // accepted at the last rising edge: predict and move on
        expected_angles.push_back(observe_step(pending_items.pop_front()));
        accepted_in++;
        in_gap = $urandom_range(0, 3);
        if (in_gap != 0 || pending_items.size() == 0) in_valid <= 1'b0;
        else in_data <= pending_items[0];
      end else if (!in_valid && pending_items.size() != 0) begin
        if (in_gap > 0) in_gap--;
        if (in_gap == 0) begin
          in_valid <= 1'b1;
          in_data <= pending_items[0];
        end
      end
    end
  end

  // monitor: compare each accepted result with the oldest expectation
  int out_gap = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    cycles++;
    if (!rst && out_valid && !out_stall) begin
      if (expected_angles.size() == 0) begin
        $display("%0t unexpected result %p", $time, out_data);
        errors++;
      end else begin
        smo_out_t want;
        want = expected_angles.pop_front();
        if (want.rotor_angle !== out_data.rotor_angle)
          $display("%0t rotor_angle expected %0d actual %0d", $time,
                   want.rotor_angle, out_data.rotor_angle);
        if (want.emf_alpha_out !== out_data.emf_alpha_out)
          $display("%0t emf_alpha_out expected %0d actual %0d", $time,
                   want.emf_alpha_out, out_data.emf_alpha_out);
        if (want.emf_beta_out !== out_data.emf_beta_out)
          $display("%0t emf_beta_out expected %0d actual %0d", $time,
                   want.emf_beta_out, out_data.emf_beta_out);
        if (want !== out_data) errors++;
        checked_out++;
      end
    end
  end

  // receiver stall drawn per item at the falling edge, with one long hold
  always @(negedge clk) begin
    if (hold_pending && hold_left == 0 && !long_hold) begin
      long_hold <= 1'b1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
      if (hold_left == 0) hold_pending = 1'b0;
    end else if (out_valid && !out_stall) begin
      out_gap = $urandom_range(0, 3);
      out_stall <= (out_gap != 0);
    end else if (out_gap > 0) begin
      out_gap--;
      out_stall <= (out_gap != 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input longint value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 31'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DECAY:    gain_f = value & 64'h1ffff;
      REG_INPUT:    gain_g = value & 64'h7fffffff;
      REG_SLIDE:    gain_k = value & 64'h7fffffff;
      REG_FILTER:   gain_kf = value & 64'h1ffff;
      REG_BAND:     band = value & 64'h7fffffff;
      REG_BAND_INV: band_inv = value & 64'h7fffffff;
      default: ;
    endcase
  endtask

  // wait until every expected result is back, then let the block settle
  task automatic drain();
    while (pending_items.size() != 0 || in_valid || expected_angles.size() != 0)
      @(posedge clk);
    repeat (Latency) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_field(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 200000)) - 100000);
    endcase
  endfunction

  function automatic smo_in_t rand_item(int mode);
    smo_in_t it;
    it.volt_alpha = rand_field(mode);
    it.volt_beta = rand_field(mode);
    it.curr_alpha = rand_field(mode);
    it.curr_beta = rand_field(mode);
    return it;
  endfunction

  // gain settings: plausible observer, wide extremes, zero band, random gains
  task automatic apply_setting(input int which);
    case (which)
      0: begin
        write_reg(REG_DECAY, 60000); write_reg(REG_INPUT, 3000);
        write_reg(REG_SLIDE, 20 << 16); write_reg(REG_FILTER, 6000);
        write_reg(REG_BAND, 1 << 16); write_reg(REG_BAND_INV, 1 << 16);
      end
      1: begin
        write_reg(REG_DECAY, 65536); write_reg(REG_INPUT, 31'h7fffffff);
        write_reg(REG_SLIDE, 31'h7fffffff); write_reg(REG_FILTER, 65536);
        write_reg(REG_BAND, 31'h7fffffff); write_reg(REG_BAND_INV, 31'h7fffffff);
      end
      2: begin
        // zero band: always saturated control
        write_reg(REG_DECAY, 0); write_reg(REG_INPUT, 65536);
        write_reg(REG_SLIDE, 5 << 16); write_reg(REG_FILTER, 30000);
        write_reg(REG_BAND, 0); write_reg(REG_BAND_INV, 0);
      end
      default: begin
        // band and inverse disagree, random gains
        write_reg(REG_DECAY, $urandom_range(0, 65536));
        write_reg(REG_INPUT, $urandom_range(0, 200000));
        write_reg(REG_SLIDE, $urandom() & 32'h7fffffff);
        write_reg(REG_FILTER, $urandom_range(0, 65536));
        write_reg(REG_BAND, $urandom_range(0, 1 << 20));
        write_reg(REG_BAND_INV, $urandom() & 32'h7fffffff);
      end
    endcase
  endtask

  initial begin
    smo_in_t it;
    gain_f = 0; gain_g = 0; gain_k = 0; gain_kf = 0; band = 0; band_inv = 0;
    est_a = 0; est_b = 0; ctl_a = 0; ctl_b = 0; emf_a = 0; emf_b = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset gains give zero back-emf, hence a zero angle
    it = '{32'h7fffffff, 32'h80000000, 32'h00000000, 32'hffffffff};
    pending_items.push_back(it);
    drain();

    // unknown index is ignored; wide value is masked by the port width
    write_reg(RegUnused, 31'h7fffffff);
    write_reg(RegSpare, 12345);
    apply_setting(0);

    // directed: field extremes, band edge, emf on the negative x axis
    pending_items.push_back('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff});
    pending_items.push_back('{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000});
    pending_items.push_back('{32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000});
    pending_items.push_back('{32'hffffffff, 32'h00000001, 32'h00010000, 32'hffff0000});
    pending_items.push_back('{32'h00000000, 32'h80000000, 32'h00000000, 32'h7fffffff});
    pending_items.push_back('{32'h00000000, 32'h80000000, 32'h00000000, 32'h7fffffff});
    pending_items.push_back('{32'h00010000, 32'hffff0000, 32'h00010000, 32'hffff0000});
    for (int i = 0; i < 8; i++) pending_items.push_back(rand_item(2));
    drain();

    // random phases over several settings, long receiver hold in the first
    for (int ph = 0; ph < 6; ph++) begin
      apply_setting(ph == 0 ? 1 : ph == 1 ? 2 : ph == 2 ? 0 : 3);
      if (ph == 0) hold_pending = 1'b1;
      for (int i = 0; i < 85; i++) pending_items.push_back(rand_item($urandom_range(0, 3)));
      drain();
    end

    $display("covered %0d items and %0d results over several gain settings,",
             accepted_in, checked_out);
    $display("including saturated, zero-band and mismatched band cases");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
